/* rtl/htfd_pkg.sv */
// Shared types, constants and arithmetic helpers for the humidity/temperature frame decoder.
package htfd_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [17:0] TEMP_SCALE  = 18'd175000;
   localparam logic [16:0] HUM_SCALE   = 17'd100000;
   localparam logic [17:0] TEMP_OFFSET = 18'd45000;
   localparam logic [16:0] DIVISOR     = 17'd65535;

   localparam int TEMP_W      = 18;
   localparam int HUM_W       = 17;
   localparam int TEMP_PROD_W = 34;
   localparam int HUM_PROD_W  = 33;

   typedef enum logic [2:0] {
      POS_T_HI  = 3'd0,
      POS_T_LO  = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_HI  = 3'd3,
      POS_H_LO  = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   // CRC-8, MSB first, no reflection, no final XOR
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) for a 34-bit x, using 65536 = 65535 + 1 folding
   function automatic logic [17:0] div_65535(input logic [33:0] x);
      logic [17:0] q1;
      logic [18:0] r1;
      logic [2:0]  q2;
      logic [16:0] r2;
      logic        fix;
      q1  = x[33:16];
      r1  = {3'b000, x[15:0]} + {1'b0, q1};
      q2  = r1[18:16];
      r2  = {1'b0, r1[15:0]} + {14'd0, q2};
      fix = (r2 >= DIVISOR);
      return q1 + {15'd0, q2} + {17'd0, fix};
   endfunction

endpackage

/* rtl/htfd_req_if.sv */
// Request channel carrying one frame byte and its frame-start flag.
interface htfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* rtl/htfd_rsp_if.sv */
// Result channel carrying the check status and the scaled measurements.
interface htfd_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic signed [17:0] temperature_mcelsius;
   logic        [16:0] humidity_mpercent;

   modport source (output valid, output status, output temperature_mcelsius,
                   output humidity_mpercent, input ready);
   modport sink   (input valid, input status, input temperature_mcelsius,
                   input humidity_mpercent, output ready);
endinterface

/* rtl/humidity_temperature_frame_decoder_top.sv */
// Top level of the humidity/temperature frame decoder.
//
// The decoder takes one byte per request (temperature high, low, CRC, then
// humidity high, low, CRC) and checks each two-byte word against a CRC-8
// (polynomial 0x31, start 0xFF). A request with frame_start set always counts
// as the first byte of a new frame; a partial frame is dropped silently.
// After the sixth byte one result is produced: status 0 with temperature in
// milli-degrees C (-45000 + raw*175000/65535) and humidity in milli-percent
// (raw*100000/65535), or status 1 with both values zero. A byte is accepted
// every cycle unless the request side stalls. After its sixth byte, a result
// passes through the product register (constant multiplies) and then the
// result register (constant divide by 65535 and offset). The request side keeps
// accepting bytes while a result waits on the output; it stalls only when
// both the product register and the result register are full.
module humidity_temperature_frame_decoder_top (
   input  logic              clock,
   input  logic              reset,
   htfd_req_if.sink          req_chan,
   htfd_rsp_if.source        rsp_chan
);

   // Frame tracking state
   htfd_pkg::pos_type pos_ff, pos_in;
   logic [7:0]        crc_ff, crc_in;
   logic              temp_ok_ff, temp_ok_in;
   logic [15:0]       temp_raw_ff, temp_raw_in;
   logic [7:0]        hum_hi_ff, hum_hi_in;
   logic [7:0]        hum_lo_ff, hum_lo_in;

   // Product stage
   logic                                  prod_valid_ff, prod_valid_in;
   logic                                  prod_ok_ff, prod_ok_in;
   logic [htfd_pkg::TEMP_PROD_W-1:0]      prod_temp_ff, prod_temp_in;
   logic [htfd_pkg::HUM_PROD_W-1:0]       prod_hum_ff, prod_hum_in;

   // Result stage
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  status_ff, status_in;
   logic [htfd_pkg::TEMP_W-1:0]           temp_ff, temp_in;
   logic [htfd_pkg::HUM_W-1:0]            hum_ff, hum_in;

   logic              req_fire;
   logic              out_adv;
   logic              frame_done;
   htfd_pkg::pos_type eff_pos;
   logic [15:0]       hum_raw;
   logic [17:0]       temp_q;
   logic [17:0]       hum_q;

   // Advance the result register when it is empty or being drained
   assign out_adv        = !rsp_valid_ff || rsp_chan.ready;
   // Take a request unless the product register is stuck behind a full output
   assign req_chan.ready = !prod_valid_ff || out_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Realign on frame start; a stray position past the last byte restarts too
   assign eff_pos = (req_chan.frame_start || (pos_ff > htfd_pkg::POS_H_CRC))
                    ? htfd_pkg::POS_T_HI : pos_ff;

   assign frame_done = req_fire && (eff_pos == htfd_pkg::POS_H_CRC);
   assign hum_raw    = {hum_hi_ff, hum_lo_ff};

   // Frame tracking: walk the six byte positions and fold bytes into the CRC
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      temp_ok_in  = temp_ok_ff;
      temp_raw_in = temp_raw_ff;
      hum_hi_in   = hum_hi_ff;
      hum_lo_in   = hum_lo_ff;
      if (req_fire) begin
         pos_in = htfd_pkg::pos_type'(eff_pos + 3'd1);
         case (eff_pos)
            htfd_pkg::POS_T_HI: begin
               crc_in      = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, req_chan.data_byte);
               temp_raw_in = {req_chan.data_byte, 8'h00};
            end
            htfd_pkg::POS_T_LO: begin
               crc_in      = htfd_pkg::crc8_byte(crc_ff, req_chan.data_byte);
               temp_raw_in = {temp_raw_ff[15:8], req_chan.data_byte};
            end
            htfd_pkg::POS_T_CRC: begin
               temp_ok_in = (crc_ff == req_chan.data_byte);
               crc_in     = htfd_pkg::CRC_INIT;
            end
            htfd_pkg::POS_H_HI: begin
               crc_in    = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, req_chan.data_byte);
               hum_hi_in = req_chan.data_byte;
            end
            htfd_pkg::POS_H_LO: begin
               crc_in    = htfd_pkg::crc8_byte(crc_ff, req_chan.data_byte);
               hum_lo_in = req_chan.data_byte;
            end
            htfd_pkg::POS_H_CRC: begin
               crc_in = htfd_pkg::CRC_INIT;
               pos_in = htfd_pkg::POS_T_HI;
            end
            default: begin
               pos_in = htfd_pkg::POS_T_HI;
            end
         endcase
      end
   end

   // Product stage: load on the last byte, drain into the result register
   always_comb begin
      prod_valid_in = prod_valid_ff;
      prod_ok_in    = prod_ok_ff;
      prod_temp_in  = prod_temp_ff;
      prod_hum_in   = prod_hum_ff;
      if (frame_done) begin
         prod_valid_in = 1'b1;
         prod_ok_in    = temp_ok_ff && (crc_ff == req_chan.data_byte);
         prod_temp_in  = {18'd0, temp_raw_ff} * {16'd0, htfd_pkg::TEMP_SCALE};
         prod_hum_in   = {17'd0, hum_raw} * {16'd0, htfd_pkg::HUM_SCALE};
      end else if (out_adv) begin
         prod_valid_in = 1'b0;
      end
   end

   // Result stage: divide by full scale, apply offset, zero on a CRC error
   assign temp_q = htfd_pkg::div_65535(prod_temp_ff);
   assign hum_q  = htfd_pkg::div_65535({1'b0, prod_hum_ff});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      temp_in      = temp_ff;
      hum_in       = hum_ff;
      if (out_adv) begin
         rsp_valid_in = prod_valid_ff;
         status_in    = !prod_ok_ff;
         temp_in      = prod_ok_ff ? (temp_q - htfd_pkg::TEMP_OFFSET) : '0;
         hum_in       = prod_ok_ff ? hum_q[htfd_pkg::HUM_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= htfd_pkg::POS_T_HI;
         crc_ff        <= htfd_pkg::CRC_INIT;
         temp_ok_ff    <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_ok_ff    <= temp_ok_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      temp_raw_ff  <= temp_raw_in;
      hum_hi_ff    <= hum_hi_in;
      hum_lo_ff    <= hum_lo_in;
      prod_ok_ff   <= prod_ok_in;
      prod_temp_ff <= prod_temp_in;
      prod_hum_ff  <= prod_hum_in;
      status_ff    <= status_in;
      temp_ff      <= temp_in;
      hum_ff       <= hum_in;
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.status               = status_ff;
   assign rsp_chan.temperature_mcelsius = $signed(temp_ff);
   assign rsp_chan.humidity_mpercent    = hum_ff;

endmodule

/* verif/humidity_temperature_frame_decoder_top_test.sv */
// Self-checking testbench for the humidity/temperature frame decoder.
module humidity_temperature_frame_decoder_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_BYTES = 1300;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   // One request: a frame byte and its realign flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } frame_byte_type;

   // One decoded measurement as it leaves the block.
   typedef struct packed {
      logic               status;
      logic signed [17:0] temperature_mcelsius;
      logic        [16:0] humidity_mpercent;
   } reading_type;

   logic clock;
   logic reset;

   htfd_req_if req_chan ();
   htfd_rsp_if rsp_chan ();

   humidity_temperature_frame_decoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Requests waiting to go out, and readings the decoder still owes us.
   frame_byte_type byte_queue[$];
   reading_type    owed_readings[$];

   // Shadow copy of the decoder state, advanced once per accepted request.
   logic [2:0]  frame_pos   = htfd_pkg::POS_T_HI;
   logic [7:0]  word_crc    = htfd_pkg::CRC_INIT;
   logic [15:0] temp_word;
   logic [7:0]  hum_high;
   logic [7:0]  hum_low;
   logic        temp_crc_ok = 1'b0;

   // Handshake pacing.
   frame_byte_type cur_byte;
   int             req_wait = 0;
   int             rsp_wait = 0;
   logic           calm = 1'b0;
   int             cycle_count = 0;

   // Run statistics.
   int mismatch_count = 0;
   int bytes_sent     = 0;
   int realign_count  = 0;
   int good_frames    = 0;
   int bad_frames     = 0;

   // Clock: 4 ns period.
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // CRC-8, polynomial 0x31, fed MSB first one data bit at a time.
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ d[i];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ htfd_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] word_check(input logic [15:0] w);
      return crc_step(crc_step(htfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
   endfunction

   // Random per-request wait, zero in calm stretches, which force back-to-back traffic.
   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 7);
   endfunction

   // Advance the shadow decoder by one byte; queue a reading after byte six.
   function automatic void decode_byte(input frame_byte_type fb);
      logic [2:0]      pos;
      logic [7:0]      b;
      logic            ok;
      reading_type     r;
      longint unsigned scaled;
      int              temp_mc;
      b   = fb.data_byte;
      pos = frame_pos;
      // Realign on frame start; an impossible position also restarts.
      if (fb.frame_start || pos > htfd_pkg::POS_H_CRC) begin
         pos = htfd_pkg::POS_T_HI;
      end
      case (pos)
         htfd_pkg::POS_T_HI: begin
            word_crc  = crc_step(htfd_pkg::CRC_INIT, b);
            temp_word = {b, 8'h00};
         end
         htfd_pkg::POS_T_LO: begin
            word_crc  = crc_step(word_crc, b);
            temp_word = temp_word | {8'h00, b};
         end
         htfd_pkg::POS_T_CRC: begin
            temp_crc_ok = (word_crc == b);
            word_crc    = htfd_pkg::CRC_INIT;
         end
         htfd_pkg::POS_H_HI: begin
            word_crc = crc_step(htfd_pkg::CRC_INIT, b);
            hum_high = b;
         end
         htfd_pkg::POS_H_LO: begin
            word_crc = crc_step(word_crc, b);
            hum_low  = b;
         end
         default: begin
            ok = temp_crc_ok && (word_crc == b);
            r  = '0;
            r.status = !ok;
            if (ok) begin
               scaled  = longint'(temp_word) * longint'(htfd_pkg::TEMP_SCALE)
                         / longint'(htfd_pkg::DIVISOR);
               temp_mc = int'(scaled) - int'(htfd_pkg::TEMP_OFFSET);
               r.temperature_mcelsius = temp_mc[17:0];
               scaled  = longint'({hum_high, hum_low}) * longint'(htfd_pkg::HUM_SCALE)
                         / longint'(htfd_pkg::DIVISOR);
               r.humidity_mpercent = scaled[16:0];
            end
            owed_readings.push_back(r);
            word_crc  = htfd_pkg::CRC_INIT;
            frame_pos = htfd_pkg::POS_T_HI;
            return;
         end
      endcase
      frame_pos = pos + 3'd1;
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic s);
      frame_byte_type fb;
      fb.data_byte   = b;
      fb.frame_start = s;
      byte_queue.push_back(fb);
   endfunction

   // Queue a full six-byte frame; a nonzero mask corrupts that word's CRC.
   function automatic void add_frame(input logic [15:0] tw, input logic [15:0] hw,
                                     input logic s, input logic [7:0] t_mask,
                                     input logic [7:0] h_mask);
      add_byte(tw[15:8], s);
      add_byte(tw[7:0], 1'b0);
      add_byte(word_check(tw) ^ t_mask, 1'b0);
      add_byte(hw[15:8], 1'b0);
      add_byte(hw[7:0], 1'b0);
      add_byte(word_check(hw) ^ h_mask, 1'b0);
   endfunction

   // Pick a random word, now and then a full-scale extreme.
   function automatic logic [15:0] draw_word();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Cycle counter, calm-stretch toggling and the hard timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 255) begin
         calm <= ($urandom_range(0, 3) == 0);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings still owed",
                  cycle_count, owed_readings.size());
         $display("[humidity_temperature_frame_decoder_top] ERROR");
         $finish;
      end
   end

   // Request driver: hold each byte until accepted, then wait, then advance.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.data_byte   <= 8'h00;
         req_chan.frame_start <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_byte(cur_byte);
            bytes_sent++;
            if (cur_byte.frame_start) begin
               realign_count++;
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_chan.valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               cur_byte = byte_queue.pop_front();
               req_chan.data_byte   <= cur_byte.data_byte;
               req_chan.frame_start <= cur_byte.frame_start;
               req_chan.valid       <= 1'b1;
               req_wait = draw_wait();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: check each reading against the oldest owed one, then
   // draw a stall that runs down only while a result is offered.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_readings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected reading status=%0b temp=%0d hum=%0d", $realtime,
                           rsp_chan.status, rsp_chan.temperature_mcelsius,
                           rsp_chan.humidity_mpercent);
               end
            end else begin : check_reading
               reading_type want;
               want = owed_readings.pop_front();
               if (rsp_chan.status) begin
                  bad_frames++;
               end else begin
                  good_frames++;
               end
               if (rsp_chan.status !== want.status
                   || rsp_chan.temperature_mcelsius !== want.temperature_mcelsius
                   || rsp_chan.humidity_mpercent !== want.humidity_mpercent) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: reading mismatch status exp %0b got %0b,",
                              $realtime, want.status, rsp_chan.status);
                     $display("   temp exp %0d got %0d, hum exp %0d got %0d",
                              want.temperature_mcelsius, rsp_chan.temperature_mcelsius,
                              want.humidity_mpercent, rsp_chan.humidity_mpercent);
                  end
               end
            end
            rsp_wait = draw_wait();
         end else if (rsp_chan.valid && rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_chan.ready <= (rsp_wait == 0);
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int          queued;
      int          k;
      logic [15:0] tw;
      logic [15:0] hw;
      logic [7:0]  t_mask;
      logic [7:0]  h_mask;
      logic        need_start;

      reset = 1'b1;

      // Directed: field extremes, a frame that rides on the position counter,
      // a dropped partial frame, and each CRC failing on its own.
      add_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00);
      add_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00);
      add_byte(8'h12, 1'b1);
      add_byte(8'h34, 1'b0);
      add_frame(16'h8000, 16'h7FFF, 1'b1, 8'h01, 8'h00);
      add_frame(16'h6666, 16'h1234, 1'b1, 8'h00, 8'h80);

      // Random: mostly well-formed frames, some broken frames and loose noise.
      queued     = 0;
      need_start = 1'b0;
      while (queued < RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0: begin
               // Noise bytes, sometimes with a stray realign flag.
               k = $urandom_range(1, 5);
               repeat (k) begin
                  add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
               end
               queued    += k;
               need_start = 1'b1;
            end
            1: begin
               // Truncated frame, dropped when the next one realigns.
               tw = draw_word();
               hw = draw_word();
               k  = $urandom_range(1, 5);
               add_byte(tw[15:8], 1'b1);
               if (k > 1) add_byte(tw[7:0], 1'b0);
               if (k > 2) add_byte(word_check(tw), 1'b0);
               if (k > 3) add_byte(hw[15:8], 1'b0);
               if (k > 4) add_byte(hw[7:0], 1'b0);
               queued    += k;
               need_start = 1'b1;
            end
            default: begin
               tw     = draw_word();
               hw     = draw_word();
               t_mask = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
               h_mask = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
               add_frame(tw, hw, need_start || ($urandom_range(0, 1) == 1), t_mask, h_mask);
               queued    += 6;
               need_start = 1'b0;
            end
         endcase
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Let every request go out, every owed reading come back, then drain.
      while (byte_queue.size() != 0 || req_chan.valid || req_wait != 0) begin
         @(posedge clock);
      end
      while (owed_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d frame bytes (%0d realigns) over %0d cycles", bytes_sent,
               realign_count, cycle_count);
      $display("decoded %0d frames with good CRCs and %0d flagged bad, %0d mismatches",
               good_frames, bad_frames, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[humidity_temperature_frame_decoder_top] OK");
      end else begin
         $display("[humidity_temperature_frame_decoder_top] ERROR");
      end
      $finish;
   end

endmodule
